### src/hwm_pkg.sv
// ----------------------------------------------------------------------------
// hwm_pkg: shared types and constants for the harmonic wavetable mixer
// Command codes, register indexes, reset values and default sizes.
// ----------------------------------------------------------------------------
package hwm_pkg;

    localparam int HWM_HARMONICS   = 16;
    localparam int HWM_TABLE_DEPTH = 65536;

    localparam logic [15:0] WEIGHT_LIMIT  = 16'd32000;
    localparam logic [15:0] RATE_RESET    = 16'd8000;
    localparam logic [14:0] FREQ_RESET    = 15'd440;
    localparam logic [14:0] LEVEL0_RESET  = 15'd10000;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_LEVEL  = 2'd1,
        CMD_RESYNC = 2'd2,
        CMD_SAMPLE = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_RATE = 1'b0,
        REG_FREQ = 1'b1
    } t_reg;

endpackage

### src/hwm_if.sv
// ----------------------------------------------------------------------------
// hwm_if: word channels of the harmonic wavetable mixer
// Command channel in, sample channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface hwm_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  cmd;
    logic        [15:0] table_addr;
    logic signed [15:0] table_word;
    logic        [5:0]  harmonic_index;
    logic        [14:0] harmonic_level;

    modport source (output valid, cmd, table_addr, table_word, harmonic_index,
                    harmonic_level, input ready);
    modport sink   (input valid, cmd, table_addr, table_word, harmonic_index,
                    harmonic_level, output ready);
endinterface

interface hwm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic               silent;

    modport source (output valid, sample_out, silent, input ready);
    modport sink   (input valid, sample_out, silent, output ready);
endinterface

### src/harmonic_wavetable_mixer_core.sv
// ----------------------------------------------------------------------------
// harmonic_wavetable_mixer_core: additive wavetable synthesiser
// Level-weighted mix of harmonics read from one stored waveform cycle.
// ----------------------------------------------------------------------------
// Usage:
//  - i_in carries command words: load table word, set harmonic level, resync
//    phases, produce sample. Only produce gives a word on o_out.
//  - APB port: register 0 sample_rate (byte 0), register 1 base_freq (byte 4).
//    Writing sample_rate also resyncs all phases. Write only when idle.
//  - Produce first forms freq mod rate in the radix-2 divider, then walks
//    the harmonics: a skipped one only steps its phase; an active one also
//    multiplies, runs the shared divider to form the running mean and may
//    halve the weight up to twice. The result is then posted.
//  - The result sits in an output register; a new command word is taken
//    while it waits. A further produce holds at its end until o_out drains.
//  - Reset: levels read as 10000 for harmonic 1 and 0 otherwise, phases as
//    zero (valid bits, cleared at once), registers at 8000 / 440. The
//    wavetable is not cleared and must be loaded before use.
//  - TABLE_DEPTH must be a power of two; phases index it modulo its depth.
// ----------------------------------------------------------------------------
module harmonic_wavetable_mixer_core
    import hwm_pkg::*;
#(
    parameter int HARMONICS   = HWM_HARMONICS,
    parameter int TABLE_DEPTH = HWM_TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hwm_in_if.sink       i_in,
    hwm_out_if.source    o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int HW = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
    localparam logic [16:0] TD_LIM = 17'(TABLE_DEPTH);
    localparam logic [6:0]  H_LIM  = 7'(HARMONICS);
    localparam logic [HW-1:0] H_LAST = HW'(HARMONICS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FMOD, S_RD, S_WRD, S_MUL, S_MUL2, S_NUM, S_DIV, S_NORM, S_OUT
    } t_state;

    // memories
    logic [15:0] wave_mem  [TABLE_DEPTH];
    logic [14:0] level_mem [HARMONICS];
    logic [15:0] phase_mem [HARMONICS];
    logic [HARMONICS-1:0] r_lvl_vld, r_ph_vld;
    logic [15:0] r_wave_rd;
    logic [14:0] r_lvl_rd;
    logic [15:0] r_ph_rd;

    // config
    logic [15:0] r_rate;
    logic [14:0] r_freq;

    // datapath / control
    t_state r_state;
    logic [HW-1:0] r_h;
    logic [21:0] r_step;
    logic [16:0] r_fmod, r_smod;
    logic signed [16:0] r_acc;
    logic [15:0] r_w, r_t;
    logic [5:0]  r_k;
    logic        r_any;
    logic [14:0] r_lvl;
    logic signed [31:0] r_prod;
    logic signed [33:0] r_accw;
    logic        r_nsign;
    logic [32:0] r_dq;
    logic [17:0] r_drem;
    logic [16:0] r_dsor;
    logic [5:0]  r_dcnt;
    logic        r_o_valid;
    logic signed [15:0] r_o_sample;
    logic        r_o_silent;

    logic        cfg_wr, in_acc;
    logic [16:0] rate_eff;
    logic [14:0] lvl_cur;
    logic [15:0] ph_cur;
    logic [21:0] n_step;
    logic [17:0] smod_sum, ph_sum;
    logic [16:0] n_smod;
    logic [15:0] n_phase;
    logic        active;
    logic [15:0] t_val;
    logic [17:0] rem_sh;
    logic        q_bit;
    logic [32:0] pmag, psh;
    logic signed [33:0] pdiv, n_num;
    logic [32:0] nmag;
    logic [HW-1:0] lvl_wa;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (t_reg'(paddr[2]) == REG_RATE) ? {16'd0, r_rate} : {17'd0, r_freq};

    assign i_in.ready       = (r_state == S_IDLE);
    assign in_acc           = i_in.valid && i_in.ready;
    assign o_out.valid      = r_o_valid;
    assign o_out.sample_out = r_o_sample;
    assign o_out.silent     = r_o_silent;

    assign rate_eff = (r_rate == 16'd0) ? 17'h10000 : {1'b0, r_rate};

    // harmonic step and phase, kept modulo rate by running sums
    always_comb begin
        lvl_cur  = r_lvl_vld[r_h] ? r_lvl_rd : ((r_h == '0) ? LEVEL0_RESET : 15'd0);
        ph_cur   = r_ph_vld[r_h] ? r_ph_rd : 16'd0;
        n_step   = r_step + {7'd0, r_freq};
        smod_sum = {1'b0, r_smod} + {1'b0, r_fmod};
        n_smod   = (smod_sum >= {1'b0, rate_eff}) ? 17'(smod_sum - {1'b0, rate_eff})
                                                  : smod_sum[16:0];
        ph_sum   = {2'd0, ph_cur} + {1'b0, n_smod};
        n_phase  = (ph_sum >= {1'b0, rate_eff}) ? 16'(ph_sum - {1'b0, rate_eff})
                                                : ph_sum[15:0];
        active   = (lvl_cur != 15'd0) && (n_step < {6'd0, rate_eff[16:1]});
        t_val    = r_w + 16'({1'b0, lvl_cur} >> r_k);
    end

    // restoring divider step
    always_comb begin
        rem_sh = {r_drem[16:0], r_dq[32]};
        q_bit  = (rem_sh >= {1'b0, r_dsor});
    end

    // (word*level)/div, truncated toward zero, plus acc*w
    always_comb begin
        pmag  = r_prod[31] ? 33'(-{r_prod[31], r_prod}) : {1'b0, r_prod};
        psh   = pmag >> r_k;
        pdiv  = r_prod[31] ? -$signed({1'b0, psh}) : $signed({1'b0, psh});
        n_num = r_accw + pdiv;
        nmag  = n_num[33] ? 33'(-n_num) : n_num[32:0];
    end

    assign lvl_wa = i_in.harmonic_index[HW-1:0];

    // wavetable: load at idle, read at the current harmonic's phase
    always_ff @(posedge i_clk) begin
        if (in_acc && t_cmd'(i_in.cmd) == CMD_LOAD && {1'b0, i_in.table_addr} < TD_LIM) begin
            wave_mem[i_in.table_addr[AW-1:0]] <= i_in.table_word;
        end
        r_wave_rd <= wave_mem[ph_cur[AW-1:0]];
    end

    // level and phase stores
    always_ff @(posedge i_clk) begin
        if (in_acc && t_cmd'(i_in.cmd) == CMD_LEVEL && {1'b0, i_in.harmonic_index} < H_LIM) begin
            level_mem[lvl_wa] <= i_in.harmonic_level;
        end
        if (r_state == S_WRD) begin
            phase_mem[r_h] <= n_phase;
        end
        r_lvl_rd <= level_mem[r_h];
        r_ph_rd  <= phase_mem[r_h];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= RATE_RESET;
            r_freq    <= FREQ_RESET;
            r_lvl_vld <= '0;
            r_ph_vld  <= '0;
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_h       <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (t_reg'(paddr[2]))
                    REG_RATE: begin
                        r_rate   <= pwdata[15:0];
                        r_ph_vld <= '0;
                    end
                    REG_FREQ: r_freq <= pwdata[14:0];
                    default: ;
                endcase
            end
            // S_OUT reloads the output word itself when it drains
            if (r_o_valid && o_out.ready && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (t_cmd'(i_in.cmd))
                            CMD_LEVEL: begin
                                if ({1'b0, i_in.harmonic_index} < H_LIM) begin
                                    r_lvl_vld[lvl_wa] <= 1'b1;
                                end
                            end
                            CMD_RESYNC: r_ph_vld <= '0;
                            CMD_SAMPLE: begin
                                // freq mod rate through the divider
                                r_dq    <= {18'd0, r_freq};
                                r_drem  <= '0;
                                r_dsor  <= rate_eff;
                                r_dcnt  <= '0;
                                r_state <= S_FMOD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FMOD: begin
                    r_drem <= q_bit ? 18'(rem_sh - {1'b0, r_dsor}) : rem_sh;
                    r_dq   <= {r_dq[31:0], q_bit};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd32) begin
                        r_fmod  <= q_bit ? 17'(rem_sh - {1'b0, r_dsor}) : rem_sh[16:0];
                        r_smod  <= '0;
                        r_step  <= '0;
                        r_acc   <= '0;
                        r_w     <= '0;
                        r_k     <= '0;
                        r_any   <= 1'b0;
                        r_h     <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_WRD;
                S_WRD: begin
                    r_step        <= n_step;
                    r_smod        <= n_smod;
                    r_ph_vld[r_h] <= 1'b1;
                    if (active) begin
                        r_lvl   <= lvl_cur;
                        r_t     <= t_val;
                        r_state <= S_MUL;
                    end else if (r_h == H_LAST) begin
                        r_state <= S_OUT;
                    end else begin
                        r_h     <= r_h + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_MUL: begin
                    r_prod  <= 32'($signed(r_wave_rd) * $signed({1'b0, r_lvl}));
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_accw  <= 34'(r_acc * $signed({1'b0, r_w}));
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_nsign <= n_num[33];
                    r_dq    <= nmag;
                    r_drem  <= '0;
                    r_dsor  <= {1'b0, r_t};
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_drem <= q_bit ? 18'(rem_sh - {1'b0, r_dsor}) : rem_sh;
                    r_dq   <= {r_dq[31:0], q_bit};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd32) begin
                        r_acc   <= r_nsign ? -$signed({r_dq[15:0], q_bit})
                                           : $signed({r_dq[15:0], q_bit});
                        r_w     <= r_t;
                        r_any   <= 1'b1;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_w > WEIGHT_LIMIT) begin
                        r_w <= r_w >> 1;
                        r_k <= r_k + 6'd1;
                    end else if (r_h == H_LAST) begin
                        r_state <= S_OUT;
                    end else begin
                        r_h     <= r_h + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_sample <= r_any ? r_acc[15:0] : 16'sd0;
                        r_o_silent <= !r_any;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/sv/hwm_mix_checker.sv
// ----------------------------------------------------------------------------
// hwm_mix_checker: sample predictor and scoreboard for the wavetable mixer
// Watches the command, sample and register ports, mirrors the mixer state
// and compares every sample word with the predicted one.
// ----------------------------------------------------------------------------
module hwm_mix_checker
    import hwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hwm_in_if           in_ch,
    hwm_out_if          out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               silent;
    } t_mix_word;

    logic signed [15:0] wave_mem [HWM_TABLE_DEPTH];
    logic        [14:0] level_mem [HWM_HARMONICS];
    logic        [15:0] phase_mem [HWM_HARMONICS];
    logic        [15:0] rate_reg;
    logic        [14:0] freq_reg;
    t_mix_word          sample_queue [$];

    task automatic clear_state();
        foreach (wave_mem[i]) wave_mem[i] = '0;
        foreach (level_mem[i]) level_mem[i] = '0;
        foreach (phase_mem[i]) phase_mem[i] = '0;
        level_mem[0] = LEVEL0_RESET;
        rate_reg     = RATE_RESET;
        freq_reg     = FREQ_RESET;
    endtask

    // weighted running mean over the harmonics; phases step for all of them
    function automatic t_mix_word mix_harmonics();
        t_mix_word res;
        longint acc, wgt, dv, t, lvl, wv;
        int     span, step, h;
        logic   any;
        acc  = 0;
        wgt  = 0;
        dv   = 1;
        any  = 1'b0;
        span = (rate_reg == 0) ? 65536 : int'(rate_reg);
        for (h = 1; h <= HWM_HARMONICS; h++) begin
            step = h * int'(freq_reg);
            lvl  = longint'(level_mem[h-1]);
            if (lvl != 0 && step < span / 2) begin
                t = wgt + lvl / dv;
                if (t != 0) begin
                    wv  = longint'(wave_mem[phase_mem[h-1]]);
                    acc = (acc * wgt + (wv * lvl) / dv) / t;
                    any = 1'b1;
                    wgt = t;
                    while (wgt > longint'(WEIGHT_LIMIT)) begin
                        wgt = wgt >>> 1;
                        dv  = dv <<< 1;
                    end
                end
            end
            phase_mem[h-1] = 16'((int'(phase_mem[h-1]) + step) % span);
        end
        if (!any) acc = 0;
        res.sample = acc[15:0];
        res.silent = !any;
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_checked    = 0;
        o_pending    = 0;
        clear_state();
    end

    always @(posedge i_clk) begin
        t_mix_word got, want;
        if (!i_rst_n) begin
            clear_state();
            sample_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg'(paddr[2]))
                    REG_RATE: begin
                        rate_reg = pwdata[15:0];
                        foreach (phase_mem[i]) phase_mem[i] = '0;
                    end
                    REG_FREQ: freq_reg = pwdata[14:0];
                endcase
            end
            // drain first: a word leaving now belongs to an older command
            if (out_ch.valid && out_ch.ready) begin
                got.sample = out_ch.sample_out;
                got.silent = out_ch.silent;
                o_checked++;
                if (sample_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected sample word %0d silent %0b",
                                 $realtime, got.sample, got.silent);
                end else begin
                    want = sample_queue.pop_front();
                    if (got.sample !== want.sample || got.silent !== want.silent) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: sample mismatch exp %0d/%0b got %0d/%0b",
                                     $realtime, want.sample, want.silent,
                                     got.sample, got.silent);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                case (t_cmd'(in_ch.cmd))
                    CMD_LOAD:   wave_mem[in_ch.table_addr] = in_ch.table_word;
                    CMD_LEVEL:  if (in_ch.harmonic_index < HWM_HARMONICS)
                                    level_mem[in_ch.harmonic_index] = in_ch.harmonic_level;
                    CMD_RESYNC: foreach (phase_mem[i]) phase_mem[i] = '0;
                    CMD_SAMPLE: sample_queue.push_back(mix_harmonics());
                endcase
            end
        end
        o_pending = sample_queue.size();
    end

endmodule

### tb/sv/tb_harmonic_wavetable_mixer_core.sv
// ----------------------------------------------------------------------------
// tb_harmonic_wavetable_mixer_core: regression bench for the mixer core
// Drives command words and register writes with random gaps and output
// stalls; the checker predicts each sample and scores the run.
// ----------------------------------------------------------------------------
module tb_harmonic_wavetable_mixer_core;
    import hwm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;  // covers the worst produce plus stalls
    localparam int SETTLE_CYCLES  = 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int  fail_count, pending, checked;
    int  idle_cycles;
    int  words_sent;
    int  stall_left;
    bit  no_gaps;      // stretch with back-to-back words

    hwm_in_if  in_ch();
    hwm_out_if out_ch();

    harmonic_wavetable_mixer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hwm_mix_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // mostly short gaps, the odd long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // sink side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 5) == 0) stall_left <= gap_len();
        end
    end

    // watchdog: any accepted word on either side resets it
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d samples still owed", pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one command word; valid stays high into the next word when there is no gap
    task automatic send_word(t_cmd cmd, logic [15:0] addr, logic [15:0] wd,
                             logic [5:0] idx, logic [14:0] lvl);
        int gap;
        gap = no_gaps ? 0 : gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= cmd;
        in_ch.table_addr     <= addr;
        in_ch.table_word     <= wd;
        in_ch.harmonic_index <= idx;
        in_ch.harmonic_level <= lvl;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic reg_write(t_reg idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // let every owed sample drain, then give trailing commands time to retire
    task automatic drain();
        end_burst();
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic new_setting(logic [15:0] rate, logic [14:0] freq);
        drain();
        reg_write(REG_RATE, {16'($urandom), rate});
        reg_write(REG_FREQ, {17'($urandom), freq});
    endtask

    // random words weighted toward level changes and sample requests
    task automatic random_words(int count);
        int          r;
        logic [5:0]  idx;
        logic [14:0] lvl;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            r   = $urandom_range(0, 99);
            idx = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
                0, 1:    lvl = '0;
                2:       lvl = 15'h7FFF;
                default: lvl = 15'($urandom);
            endcase
            if (r < 25)      send_word(CMD_LOAD, 16'($urandom), 16'($urandom), 6'($urandom),
                                       15'($urandom));
            else if (r < 55) send_word(CMD_LEVEL, 16'($urandom), 16'($urandom), idx, lvl);
            else if (r < 60) send_word(CMD_RESYNC, 16'($urandom), 16'($urandom),
                                       6'($urandom), 15'($urandom));
            else             send_word(CMD_SAMPLE, 16'($urandom), 16'($urandom),
                                       6'($urandom), 15'($urandom));
        end
        no_gaps = 1'b0;
    endtask

    // fill table entries [lo, hi] back to back
    task automatic fill_table(int lo, int hi);
        no_gaps = 1'b1;
        for (int a = lo; a <= hi; a++)
            send_word(CMD_LOAD, 16'(a), 16'($urandom), '0, '0);
        no_gaps = 1'b0;
    endtask

    // load entries k*stride for k = 1..count-1, back to back
    task automatic fill_stride(int stride, int count);
        no_gaps = 1'b1;
        for (int k = 1; k < count; k++)
            send_word(CMD_LOAD, 16'(k * stride), 16'($urandom), '0, '0);
        no_gaps = 1'b0;
    endtask

    initial begin
        // everything known from time zero
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.cmd            = CMD_LOAD;
        in_ch.table_addr     = '0;
        in_ch.table_word     = '0;
        in_ch.harmonic_index = '0;
        in_ch.harmonic_level = '0;
        out_ch.ready         = 1'b0;
        stall_left           = 0;
        idle_cycles          = 0;
        words_sent           = 0;
        no_gaps              = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // small table first: every phase stays below 64, entries 0..63 loaded
        reg_write(REG_RATE, 32'd64);
        reg_write(REG_FREQ, 32'd3);
        fill_table(0, 63);

        // directed: field extremes, ignored writes, weight halving, silence
        send_word(CMD_LOAD,   16'hFFFF, 16'sh7FFF, '0, '0);
        send_word(CMD_LOAD,   16'd0,    16'sh8000, '0, '0);
        send_word(CMD_LOAD,   16'd1,    16'sh7FFF, '0, '0);
        send_word(CMD_SAMPLE, '0, '0, '0, '0);              // reset level of h1 only
        send_word(CMD_LEVEL,  '0, '0, 6'd63, 15'h7FFF);     // index past harmonics
        send_word(CMD_LEVEL,  '0, '0, 6'd16, 15'd5);        // first index out of range
        send_word(CMD_LEVEL,  '0, '0, 6'd15, 15'h7FFF);
        send_word(CMD_LEVEL,  '0, '0, 6'd1,  15'h7FFF);
        send_word(CMD_SAMPLE, '1, '1, '1, '1);              // weight passes the limit
        send_word(CMD_RESYNC, '1, '1, '1, '1);
        send_word(CMD_SAMPLE, '0, '0, '0, '0);
        send_word(CMD_LEVEL,  '0, '0, 6'd0,  15'd0);
        send_word(CMD_LEVEL,  '0, '0, 6'd1,  15'd0);
        send_word(CMD_LEVEL,  '0, '0, 6'd15, 15'd0);
        send_word(CMD_SAMPLE, '0, '0, '0, '0);              // no active harmonic
        send_word(CMD_LEVEL,  '0, '0, 6'd0,  15'h7FFF);
        send_word(CMD_LEVEL,  '0, '0, 6'd2,  15'd1);
        send_word(CMD_SAMPLE, '0, '0, '0, '0);
        random_words(100);

        // rate of one: nothing can stay under Nyquist
        new_setting(16'd1, 15'd0);
        random_words(20);
        // top frequency: every harmonic skipped
        new_setting(16'd64, 15'h7FFF);
        random_words(20);
        new_setting(16'd50, 15'd7);
        random_words(100);

        // wide rates: the frequency divides the rate, so phases only land on
        // multiples of it, and just those entries are loaded
        drain();
        fill_stride(4369, 15);
        fill_stride(4096, 16);
        new_setting(16'hFFFF, 15'd4369);
        random_words(100);
        // zero rate: phases wrap in 16 bits
        new_setting(16'd0, 15'd4096);
        random_words(100);
        // zero frequency: every harmonic with a nonzero level active, phases frozen
        new_setting(16'd0, 15'd0);
        random_words(30);

        drain();
        $display("%0d command words sent, %0d sample words checked", words_sent, checked);
        $display("rates 0..65535 with frequencies 0..32767, gaps and stalls on both sides");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d failures", fail_count + pending);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
